/* hdl/tmsc_pkg.sv */
// ----------------------------------------------------------------------------
// tmsc_pkg
// Shared types and constants of the text mode sprite compositor.
// ----------------------------------------------------------------------------
package tmsc_pkg;

    typedef enum logic [2:0] {
        OP_SCREEN = 3'd0,
        OP_COLOR  = 3'd1,
        OP_GLYPH  = 3'd2,
        OP_SBYTE  = 3'd3,
        OP_SATTR  = 3'd4,
        OP_RENDER = 3'd5
    } opcode_t;

    localparam int unsigned FRAME_W    = 320;
    localparam int unsigned FRAME_H    = 200;
    localparam int unsigned ORIGIN_X   = 24;
    localparam int unsigned ORIGIN_Y   = 50;
    localparam int unsigned SPRITE_W   = 24;
    localparam int unsigned SPRITE_H   = 21;
    localparam int unsigned CELL_DEPTH = 1000;
    localparam int unsigned SPR_MAX    = 8;

    // one queued item as the back end sees it
    typedef struct packed {
        opcode_t     op;
        logic [10:0] address;
        logic [7:0]  data;
        logic [8:0]  sprite_x;
        logic [7:0]  sprite_y;
        logic [3:0]  sprite_color;
        logic [3:0]  sprite_flags;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
    } item_t;

endpackage

/* hdl/tmsc_front.sv */
// ----------------------------------------------------------------------------
// tmsc_front
// Accepts items, drops unknown opcodes and queues the rest for the back end.
// A two-entry queue sits between accept and the back end.
// ----------------------------------------------------------------------------
module tmsc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [10:0]        s_address,
    input  logic [7:0]         s_data,
    input  logic [8:0]         s_sprite_x,
    input  logic [7:0]         s_sprite_y,
    input  logic [3:0]         s_sprite_color,
    input  logic [3:0]         s_sprite_flags,
    input  logic [8:0]         s_pixel_x,
    input  logic [7:0]         s_pixel_y,
    output logic               q_valid,
    input  logic               q_ready,
    output tmsc_pkg::item_t    q_item
);

    tmsc_pkg::item_t q_mem_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push, pop;

    assign s_ready = (count_reg != 2'd2);
    // everything but unknown opcodes is queued, in arrival order
    assign push    = s_valid && s_ready && (s_opcode <= 3'(tmsc_pkg::OP_RENDER));
    assign pop     = q_valid && q_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    // queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{op: tmsc_pkg::opcode_t'(s_opcode),
                                       address: s_address, data: s_data,
                                       sprite_x: s_sprite_x, sprite_y: s_sprite_y,
                                       sprite_color: s_sprite_color,
                                       sprite_flags: s_sprite_flags,
                                       pixel_x: s_pixel_x, pixel_y: s_pixel_y};
        end
    end

    // never more than two items held
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue overfilled");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_empty_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

/* hdl/tmsc_back.sv */
// ----------------------------------------------------------------------------
// tmsc_back
// Carries out store and sprite attribute writes and renders pixels in a
// four-stage pipeline: cell read, glyph and sprite byte reads with sprite hit
// tests, text and sprite pixels, compose.
// ----------------------------------------------------------------------------
module tmsc_back #(
    parameter int unsigned SPRITE_COUNT = 8,
    parameter int unsigned TEXT_COLUMNS = 40,
    parameter int unsigned TEXT_ROWS    = 25
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [3:0]         background_color,
    input  logic               q_valid,
    output logic               q_ready,
    input  tmsc_pkg::item_t    q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_pixel_color
);

    localparam int unsigned CELLS = TEXT_COLUMNS * TEXT_ROWS;

    // stores
    logic [7:0] screen_mem [tmsc_pkg::CELL_DEPTH];
    logic [3:0] color_mem  [tmsc_pkg::CELL_DEPTH];
    logic [7:0] glyph_mem  [2048];

    // sprite attributes
    logic [8:0] spr_x_reg    [SPRITE_COUNT];
    logic [7:0] spr_y_reg    [SPRITE_COUNT];
    logic [3:0] spr_col_reg  [SPRITE_COUNT];
    logic [3:0] spr_mode_reg [SPRITE_COUNT];

    logic adv;
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;

    // pipeline moves when the output slot is free or being emptied
    assign adv     = !out_v_reg || m_ready;
    assign q_ready = adv;
    assign m_valid = out_v_reg;

    logic take;
    assign take = q_valid && adv;

    // ---- stage 0: writes and address formation
    logic [9:0] cell_addr;
    logic       in_text, in_frame;
    logic [5:0] col;
    logic [4:0] row;
    always_comb begin
        col       = q_item.pixel_x[8:3];
        row       = q_item.pixel_y[7:3];
        in_frame  = (q_item.pixel_x < 9'(tmsc_pkg::FRAME_W)) &&
                    (q_item.pixel_y < 8'(tmsc_pkg::FRAME_H));
        in_text   = (32'(col) < TEXT_COLUMNS) && (32'(row) < TEXT_ROWS);
        cell_addr = 10'(row * 10'(TEXT_COLUMNS) + 10'(col));
    end

    always_ff @(posedge aclk) begin
        if (take && q_item.op == tmsc_pkg::OP_SCREEN && 32'(q_item.address) < CELLS)
            screen_mem[q_item.address[9:0]] <= q_item.data;
        if (take && q_item.op == tmsc_pkg::OP_COLOR && 32'(q_item.address) < CELLS)
            color_mem[q_item.address[9:0]] <= q_item.data[3:0];
        if (take && q_item.op == tmsc_pkg::OP_GLYPH)
            glyph_mem[q_item.address] <= q_item.data;
    end

    // sprite attribute registers, written in item order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SPRITE_COUNT; i++) begin
                spr_x_reg[i]    <= '0;
                spr_y_reg[i]    <= '0;
                spr_col_reg[i]  <= '0;
                spr_mode_reg[i] <= '0;
            end
        end else if (take && q_item.op == tmsc_pkg::OP_SATTR) begin
            for (int i = 0; i < SPRITE_COUNT; i++) begin
                if (q_item.address == 11'(i)) begin
                    spr_x_reg[i]    <= q_item.sprite_x;
                    spr_y_reg[i]    <= q_item.sprite_y;
                    spr_col_reg[i]  <= q_item.sprite_color;
                    spr_mode_reg[i] <= q_item.sprite_flags;
                end
            end
        end
    end

    // ---- stage 1: cell code and colour
    logic [7:0] s1_code_reg;
    logic [3:0] s1_ccol_reg;
    logic       s1_text_reg, s1_frame_reg;
    logic [8:0] s1_x_reg;
    logic [7:0] s1_y_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_code_reg  <= screen_mem[cell_addr];
            s1_ccol_reg  <= color_mem[cell_addr];
            s1_text_reg  <= in_text;
            s1_frame_reg <= in_frame;
            s1_x_reg     <= q_item.pixel_x;
            s1_y_reg     <= q_item.pixel_y;
        end
    end

    // ---- stage 2: glyph row, sprite hit tests and byte addresses in parallel
    logic [9:0] rx;
    logic [8:0] ry;
    logic [SPRITE_COUNT-1:0] hit;
    logic [4:0] bx [SPRITE_COUNT];
    logic [4:0] by [SPRITE_COUNT];
    logic [5:0] sidx [SPRITE_COUNT];
    always_comb begin
        logic [9:0] dx;
        logic [8:0] dy;
        logic [3:0] md;
        rx = 10'(s1_x_reg) + 10'(tmsc_pkg::ORIGIN_X);
        ry = 9'(s1_y_reg) + 9'(tmsc_pkg::ORIGIN_Y);
        for (int i = 0; i < SPRITE_COUNT; i++) begin
            md      = spr_mode_reg[i];
            dx      = rx - 10'(spr_x_reg[i]);
            dy      = ry - 9'(spr_y_reg[i]);
            bx[i]   = md[1] ? dx[5:1] : dx[4:0];
            by[i]   = md[2] ? dy[5:1] : dy[4:0];
            hit[i]  = md[0] && (rx >= 10'(spr_x_reg[i])) &&
                      (ry >= 9'(spr_y_reg[i])) &&
                      ((md[1] ? 10'(dx[9:1]) : dx) < 10'(tmsc_pkg::SPRITE_W)) &&
                      ((md[2] ? 9'(dy[8:1]) : dy) < 9'(tmsc_pkg::SPRITE_H));
            sidx[i] = 6'(by[i]) * 6'd3 + 6'(bx[i][4:3]);
        end
    end

    logic [7:0] s2_glyph_reg;
    logic [2:0] s2_gbit_reg;
    logic [3:0] s2_ccol_reg;
    logic       s2_text_reg, s2_frame_reg;
    logic [SPRITE_COUNT-1:0] s2_hit_reg;
    logic [SPRITE_COUNT-1:0] s2_behind_reg;
    logic [2:0] s2_sbit_reg [SPRITE_COUNT];
    logic [3:0] s2_scol_reg [SPRITE_COUNT];
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_glyph_reg <= glyph_mem[{s1_code_reg, s1_y_reg[2:0]}];
            s2_gbit_reg  <= s1_x_reg[2:0];
            s2_ccol_reg  <= s1_ccol_reg;
            s2_text_reg  <= s1_text_reg;
            s2_frame_reg <= s1_frame_reg;
            s2_hit_reg   <= hit;
            for (int i = 0; i < SPRITE_COUNT; i++) begin
                s2_sbit_reg[i]   <= bx[i][2:0];
                s2_scol_reg[i]   <= spr_col_reg[i];
                s2_behind_reg[i] <= spr_mode_reg[i][3];
            end
        end
    end

    // one bitmap bank per sprite, read with the glyph row
    logic [SPRITE_COUNT-1:0] opaque;
    for (genvar g = 0; g < SPRITE_COUNT; g++) begin : g_bank
        logic [7:0] bank_mem [64];
        logic [7:0] sbyte_reg;
        always_ff @(posedge aclk) begin
            if (take && q_item.op == tmsc_pkg::OP_SBYTE &&
                q_item.address[10:6] == 5'(g))
                bank_mem[q_item.address[5:0]] <= q_item.data;
            if (adv) sbyte_reg <= bank_mem[sidx[g]];
        end
        assign opaque[g] = s2_hit_reg[g] && sbyte_reg[3'd7 - s2_sbit_reg[g]];
    end

    // ---- stage 3: sprite pixels, text pixel
    logic [SPRITE_COUNT-1:0] s3_opq_reg;
    logic [SPRITE_COUNT-1:0] s3_behind_reg;
    logic [3:0] s3_scol_reg [SPRITE_COUNT];
    logic       s3_fg_reg, s3_frame_reg;
    logic [3:0] s3_ccol_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_opq_reg    <= opaque;
            s3_behind_reg <= s2_behind_reg;
            for (int i = 0; i < SPRITE_COUNT; i++)
                s3_scol_reg[i] <= s2_scol_reg[i];
            s3_fg_reg     <= s2_text_reg && s2_glyph_reg[3'd7 - s2_gbit_reg];
            s3_frame_reg  <= s2_frame_reg;
            s3_ccol_reg   <= s2_ccol_reg;
        end
    end

    // ---- compose: first opaque sprite wins
    logic [3:0] color;
    always_comb begin
        logic done;
        color = s3_fg_reg ? s3_ccol_reg : background_color;
        done  = 1'b0;
        for (int i = 0; i < SPRITE_COUNT; i++) begin
            if (!done && s3_opq_reg[i]) begin
                done = 1'b1;
                if (!s3_behind_reg[i] || !s3_fg_reg)
                    color = s3_scol_reg[i];
            end
        end
        if (!s3_frame_reg) color = background_color;
    end

    logic [3:0] out_col_reg;
    always_ff @(posedge aclk) begin
        if (adv) out_col_reg <= color;
    end
    assign m_pixel_color = out_col_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg  <= take && q_item.op == tmsc_pkg::OP_RENDER;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            out_v_reg <= s3_v_reg;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && !m_ready |=> out_v_reg && $stable(out_col_reg))
        else $error("result lost under stall");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s3_v_reg |=> out_v_reg) else $error("result dropped");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> !q_ready) else $error("item taken during stall");

endmodule

/* hdl/text_mode_sprite_compositor.sv */
// ----------------------------------------------------------------------------
// text_mode_sprite_compositor
// Text screen with eight one-bit sprites; renders one pixel colour per render item.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid/s_ready, opcode address data sprite_* pixel_*
//  m_      | out       | m_valid/m_ready, pixel_color
//  cfg     | in        | cfg_wr_en, cfg_wr_data (background colour)
//
// One item per cycle sustained while the output is not stalled; a render result
// follows the two-entry queue and four-stage back end. Writes give no result.
// Stores have no reset; sprite attributes and background reset to zero.
// A stalled output holds the back end; the queue then fills and s_ready drops.
module text_mode_sprite_compositor #(
    parameter int unsigned SPRITE_COUNT = 8,
    parameter int unsigned TEXT_COLUMNS = 40,
    parameter int unsigned TEXT_ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [10:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [8:0]  s_sprite_x,
    input  logic [7:0]  s_sprite_y,
    input  logic [3:0]  s_sprite_color,
    input  logic [3:0]  s_sprite_flags,
    input  logic [8:0]  s_pixel_x,
    input  logic [7:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_pixel_color
);

    logic [3:0] bg_reg;
    logic q_valid, q_ready;
    tmsc_pkg::item_t q_item;

    // background register
    always_ff @(posedge aclk) begin
        if (!aresetn) bg_reg <= '0;
        else if (cfg_wr_en) bg_reg <= cfg_wr_data;
    end

    tmsc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_address, .s_data,
        .s_sprite_x, .s_sprite_y, .s_sprite_color, .s_sprite_flags,
        .s_pixel_x, .s_pixel_y, .q_valid, .q_ready, .q_item
    );

    tmsc_back #(.SPRITE_COUNT(SPRITE_COUNT), .TEXT_COLUMNS(TEXT_COLUMNS),
                .TEXT_ROWS(TEXT_ROWS)) u_back (
        .aclk, .aresetn, .background_color(bg_reg), .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_pixel_color
    );

endmodule

/* sim/text_mode_sprite_compositor_test.sv */
// ----------------------------------------------------------------------------
// text_mode_sprite_compositor_test
// Self-checking bench: loads text, font and sprite stores, renders pixels
// and checks every colour against an in-bench model of the compositor.
// ----------------------------------------------------------------------------
module text_mode_sprite_compositor_test;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int         COLUMNS    = 40;
    localparam int         SLOT       = 64;
    localparam int         DRAIN_WAIT = 20;

    typedef struct {
        logic [2:0]  op;
        logic [10:0] addr;
        logic [7:0]  data;
        logic [8:0]  sx;
        logic [7:0]  sy;
        logic [3:0]  scol;
        logic [3:0]  sflg;
        logic [8:0]  px;
        logic [7:0]  py;
    } cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [10:0] s_address = '0;
    logic [7:0]  s_data = '0;
    logic [8:0]  s_sprite_x = '0;
    logic [7:0]  s_sprite_y = '0;
    logic [3:0]  s_sprite_color = '0;
    logic [3:0]  s_sprite_flags = '0;
    logic [8:0]  s_pixel_x = '0;
    logic [7:0]  s_pixel_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_pixel_color;

    // model state, updated as items are accepted
    logic [3:0] bg_colour = '0;
    logic [7:0] codes_mem [tmsc_pkg::CELL_DEPTH];
    logic [3:0] colours_mem [tmsc_pkg::CELL_DEPTH];
    logic [7:0] glyph_mem [2048];
    logic [7:0] sprite_mem [512];
    logic [8:0] spr_x [tmsc_pkg::SPR_MAX];
    logic [7:0] spr_y [tmsc_pkg::SPR_MAX];
    logic [3:0] spr_col [tmsc_pkg::SPR_MAX];
    logic [3:0] spr_mode [tmsc_pkg::SPR_MAX];

    // generation-side view of what has been written
    bit         code_ok [tmsc_pkg::CELL_DEPTH];
    bit         colour_ok [tmsc_pkg::CELL_DEPTH];
    bit         glyph_ok [2048];
    bit         sbyte_ok [512];
    logic [7:0] g_code [tmsc_pkg::CELL_DEPTH];
    int         g_sx [tmsc_pkg::SPR_MAX];
    int         g_sy [tmsc_pkg::SPR_MAX];
    logic [3:0] g_mode [tmsc_pkg::SPR_MAX];

    cmd_t       pending_items [$];
    logic [3:0] expected_colours [$];
    cmd_t       cur;
    bit         taken = 0;
    int         send_idle = 20;
    int         recv_idle = 51;
    bit         hold_off = 0;
    int         phase = 0;
    int         errors = 0;

    text_mode_sprite_compositor u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_address     (s_address),
        .s_data        (s_data),
        .s_sprite_x    (s_sprite_x),
        .s_sprite_y    (s_sprite_y),
        .s_sprite_color(s_sprite_color),
        .s_sprite_flags(s_sprite_flags),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        for (int s = 0; s < tmsc_pkg::SPR_MAX; s++) begin
            spr_x[s] = '0; spr_y[s] = '0; spr_col[s] = '0; spr_mode[s] = '0;
            g_sx[s] = 0; g_sy[s] = 0; g_mode[s] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // opaque sprite pixel at raster position
    function automatic bit sprite_hit(int s, int rx, int ry);
        int dx, dy, bx, by;
        if (!spr_mode[s][0] || rx < spr_x[s] || ry < spr_y[s]) return 0;
        dx = rx - spr_x[s];
        dy = ry - spr_y[s];
        bx = spr_mode[s][1] ? dx / 2 : dx;
        by = spr_mode[s][2] ? dy / 2 : dy;
        if (bx >= tmsc_pkg::SPRITE_W || by >= tmsc_pkg::SPRITE_H) return 0;
        return sprite_mem[s * SLOT + by * 3 + bx / 8][7 - bx % 8];
    endfunction

    function automatic logic [3:0] pixel_colour(int px, int py);
        logic [3:0] c;
        logic [7:0] g;
        bit         fg;
        int         cell_idx;
        if (px >= tmsc_pkg::FRAME_W || py >= tmsc_pkg::FRAME_H) return bg_colour;
        cell_idx = (py / 8) * COLUMNS + px / 8;
        g = glyph_mem[codes_mem[cell_idx] * 8 + py % 8];
        fg = g[7 - px % 8];
        c = fg ? colours_mem[cell_idx] : bg_colour;
        // lowest sprite number wins, even when hidden behind text
        for (int s = 0; s < tmsc_pkg::SPR_MAX; s++) begin
            if (sprite_hit(s, px + tmsc_pkg::ORIGIN_X, py + tmsc_pkg::ORIGIN_Y)) begin
                if (!spr_mode[s][3] || !fg) c = spr_col[s];
                break;
            end
        end
        return c;
    endfunction

    task automatic apply_item(input cmd_t c);
        case (c.op)
            tmsc_pkg::OP_SCREEN: if (c.addr < tmsc_pkg::CELL_DEPTH) codes_mem[c.addr] = c.data;
            tmsc_pkg::OP_COLOR:  if (c.addr < tmsc_pkg::CELL_DEPTH)
                colours_mem[c.addr] = c.data[3:0];
            tmsc_pkg::OP_GLYPH:  glyph_mem[c.addr] = c.data;
            tmsc_pkg::OP_SBYTE:  if (c.addr < tmsc_pkg::SPR_MAX * SLOT)
                sprite_mem[c.addr] = c.data;
            tmsc_pkg::OP_SATTR:  if (c.addr < tmsc_pkg::SPR_MAX) begin
                spr_x[c.addr] = c.sx; spr_y[c.addr] = c.sy;
                spr_col[c.addr] = c.scol; spr_mode[c.addr] = c.sflg;
            end
            tmsc_pkg::OP_RENDER: expected_colours.push_back(pixel_colour(c.px, c.py));
            default: ;
        endcase
    endtask

    function automatic cmd_t random_cmd(logic [2:0] op);
        cmd_t c;
        c.op = op;
        c.addr = 11'($urandom); c.data = 8'($urandom);
        c.sx = 9'($urandom); c.sy = 8'($urandom);
        c.scol = 4'($urandom); c.sflg = 4'($urandom);
        c.px = 9'($urandom); c.py = 8'($urandom);
        return c;
    endfunction

    task automatic queue_item(input cmd_t c);
        case (c.op)
            tmsc_pkg::OP_SCREEN: if (c.addr < tmsc_pkg::CELL_DEPTH) begin
                code_ok[c.addr] = 1; g_code[c.addr] = c.data;
            end
            tmsc_pkg::OP_COLOR:  if (c.addr < tmsc_pkg::CELL_DEPTH) colour_ok[c.addr] = 1;
            tmsc_pkg::OP_GLYPH:  glyph_ok[c.addr] = 1;
            tmsc_pkg::OP_SBYTE:  if (c.addr < tmsc_pkg::SPR_MAX * SLOT) sbyte_ok[c.addr] = 1;
            tmsc_pkg::OP_SATTR:  if (c.addr < tmsc_pkg::SPR_MAX) begin
                g_sx[c.addr] = c.sx; g_sy[c.addr] = c.sy; g_mode[c.addr] = c.sflg;
            end
            default: ;
        endcase
        pending_items.push_back(c);
    endtask

    task automatic write_item(input logic [2:0] op, input int addr, input int data);
        cmd_t c;
        c = random_cmd(op);
        c.addr = 11'(addr);
        c.data = 8'(data);
        queue_item(c);
    endtask

    task automatic sprite_attr(input int s, input int x, input int y, input int col,
                               input int flg);
        cmd_t c;
        c = random_cmd(tmsc_pkg::OP_SATTR);
        c.addr = 11'(s); c.sx = 9'(x); c.sy = 8'(y); c.scol = 4'(col); c.sflg = 4'(flg);
        queue_item(c);
    endtask

    // load whatever entries this pixel will read, then render it
    task automatic render_at(input int px, input int py);
        cmd_t c;
        int   cell_idx, gi, dx, dy, bx, by, idx;
        if (px < tmsc_pkg::FRAME_W && py < tmsc_pkg::FRAME_H) begin
            cell_idx = (py / 8) * COLUMNS + px / 8;
            if (!code_ok[cell_idx])
                write_item(tmsc_pkg::OP_SCREEN, cell_idx, $urandom_range(0, 15));
            if (!colour_ok[cell_idx]) write_item(tmsc_pkg::OP_COLOR, cell_idx, $urandom);
            gi = g_code[cell_idx] * 8 + py % 8;
            if (!glyph_ok[gi]) write_item(tmsc_pkg::OP_GLYPH, gi, $urandom);
            for (int s = 0; s < tmsc_pkg::SPR_MAX; s++) begin
                dx = px + tmsc_pkg::ORIGIN_X - g_sx[s];
                dy = py + tmsc_pkg::ORIGIN_Y - g_sy[s];
                bx = g_mode[s][1] ? dx / 2 : dx;
                by = g_mode[s][2] ? dy / 2 : dy;
                if (dx >= 0 && dy >= 0 && bx < tmsc_pkg::SPRITE_W && by < tmsc_pkg::SPRITE_H)
                begin
                    idx = s * SLOT + by * 3 + bx / 8;
                    if (!sbyte_ok[idx]) write_item(tmsc_pkg::OP_SBYTE, idx, $urandom);
                end
            end
        end
        c = random_cmd(tmsc_pkg::OP_RENDER);
        c.px = 9'(px); c.py = 8'(py);
        queue_item(c);
    endtask

    task automatic set_background(input logic [3:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        bg_colour = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || s_valid || expected_colours.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        int r, s, px, py;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                // aim at a sprite box
                s = $urandom_range(0, tmsc_pkg::SPR_MAX - 1);
                px = g_sx[s] - tmsc_pkg::ORIGIN_X + $urandom_range(0, 47);
                py = g_sy[s] - tmsc_pkg::ORIGIN_Y + $urandom_range(0, 41);
                if (px < 0 || px >= tmsc_pkg::FRAME_W)
                    px = $urandom_range(0, tmsc_pkg::FRAME_W - 1);
                if (py < 0 || py >= tmsc_pkg::FRAME_H)
                    py = $urandom_range(0, tmsc_pkg::FRAME_H - 1);
                render_at(px, py);
            end else if (r < 42) begin
                render_at($urandom_range(0, tmsc_pkg::FRAME_W - 1),
                          $urandom_range(0, tmsc_pkg::FRAME_H - 1));
            end else if (r < 45) begin
                render_at($urandom_range(0, 511), $urandom_range(0, 255));
            end else if (r < 55) begin
                sprite_attr($urandom_range(0, 8),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                        : $urandom_range(0, 360),
                            $urandom_range(30, 255), $urandom, $urandom);
            end else if (r < 65) begin
                write_item(tmsc_pkg::OP_SBYTE, $urandom_range(0, 600), $urandom);
            end else if (r < 75) begin
                write_item(tmsc_pkg::OP_GLYPH, $urandom_range(0, 2047), $urandom);
            end else if (r < 83) begin
                write_item(tmsc_pkg::OP_SCREEN, $urandom_range(0, 1100),
                           ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 15));
            end else if (r < 95) begin
                write_item(tmsc_pkg::OP_COLOR, $urandom_range(0, 1100), $urandom);
            end else begin
                queue_item(random_cmd(($urandom_range(0, 1) == 1) ? OP_SPARE_A : OP_SPARE_B));
            end
        end
    endtask

    // sender: present the next item after the previous one went in
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                cur = pending_items.pop_front();
                s_opcode <= cur.op;
                s_address <= cur.addr;
                s_data <= cur.data;
                s_sprite_x <= cur.sx;
                s_sprite_y <= cur.sy;
                s_sprite_color <= cur.scol;
                s_sprite_flags <= cur.sflg;
                s_pixel_x <= cur.px;
                s_pixel_y <= cur.py;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with random stalls and the long hold-off
    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
    end

    // accept items into the model and check results
    always @(posedge aclk) begin
        taken = aresetn && s_valid && s_ready;
        if (taken) apply_item(cur);
        if (aresetn && m_valid && m_ready) begin
            if (expected_colours.size() == 0) begin
                report_mismatch("unexpected pixel_color", m_pixel_color, 4'd0);
            end else begin
                if (m_pixel_color !== expected_colours[0])
                    report_mismatch("pixel_color", m_pixel_color, expected_colours[0]);
                void'(expected_colours.pop_front());
            end
        end
    end

    // long output stall so the block backs up onto its input
    initial begin
        wait (phase == 1);
        hold_off = 1;
        repeat (300) @(posedge aclk);
        hold_off = 0;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed items with the reset background
        write_item(tmsc_pkg::OP_SCREEN, 0, 8'hFF);
        write_item(tmsc_pkg::OP_COLOR, 0, 8'hFF);
        write_item(tmsc_pkg::OP_GLYPH, 2040, 8'h80);
        render_at(0, 0);
        render_at(1, 0);
        write_item(tmsc_pkg::OP_SCREEN, 999, 0);
        write_item(tmsc_pkg::OP_COLOR, 999, 8'h0A);
        write_item(tmsc_pkg::OP_GLYPH, 7, 8'h01);
        render_at(319, 199);
        write_item(tmsc_pkg::OP_SCREEN, 1000, 8'h55);
        write_item(tmsc_pkg::OP_SCREEN, 2047, 8'h55);
        write_item(tmsc_pkg::OP_COLOR, 1000, 8'h05);
        write_item(tmsc_pkg::OP_GLYPH, 2047, 8'hAA);
        render_at(320, 0);
        render_at(0, 200);
        render_at(511, 255);
        write_item(tmsc_pkg::OP_SBYTE, 511, 8'hFF);
        write_item(tmsc_pkg::OP_SBYTE, 512, 8'hFF);
        write_item(tmsc_pkg::OP_SBYTE, 0, 8'hFF);
        write_item(tmsc_pkg::OP_SBYTE, 64, 8'hFF);
        sprite_attr(0, tmsc_pkg::ORIGIN_X, tmsc_pkg::ORIGIN_Y, 3, 4'b0001);
        render_at(0, 0);
        // behind text: hidden by foreground, still blocks sprite 1
        sprite_attr(0, tmsc_pkg::ORIGIN_X, tmsc_pkg::ORIGIN_Y, 3, 4'b1001);
        sprite_attr(1, tmsc_pkg::ORIGIN_X, tmsc_pkg::ORIGIN_Y, 5, 4'b0001);
        render_at(0, 0);
        render_at(1, 0);
        // double size sprites and an ignored sprite number
        sprite_attr(7, 511, 255, 9, 4'b0111);
        sprite_attr(2, tmsc_pkg::ORIGIN_X + 300, tmsc_pkg::ORIGIN_Y + 180, 12, 4'b0111);
        sprite_attr(8, 0, 0, 15, 4'b1111);
        render_at(310, 195);
        queue_item(random_cmd(OP_SPARE_A));
        queue_item(random_cmd(OP_SPARE_B));
        drain();

        set_background(4'd15);
        phase = 1;
        random_phase(300);
        drain();

        set_background(4'($urandom_range(1, 14)));
        send_idle = 51;
        recv_idle = 20;
        phase = 2;
        random_phase(300);
        drain();

        set_background(4'd0);
        send_idle = 0;
        recv_idle = 0;
        phase = 3;
        random_phase(300);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/tmsc_pkg.sv
hdl/tmsc_front.sv
hdl/tmsc_back.sv
hdl/text_mode_sprite_compositor.sv
sim/text_mode_sprite_compositor_test.sv
